FILE: hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Widths and elaboration-time constant functions for the CORDIC lanes.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int DATA_W  = 32;
   localparam int DATA_FR = 30;
   localparam int PAIR_W  = 34;
   localparam int SUM_W   = 68;
   localparam int ANG_W   = 16;
   localparam int QUAT_W  = 16;
   localparam int Q_ONE   = 16384;
   localparam int TAB_MAX = 24;
   localparam int MERGE_STAGES = 4;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ANG_W-1:0]  angle_type;
   typedef logic signed [QUAT_W-1:0] quat_type;

   // Restoring long division; the divisor stays below 2^63.
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned atan_pow2_q62(input int unsigned i);
      longint unsigned acc;
      longint unsigned t;
      int unsigned     k;
      int unsigned     n;
      acc = 64'd0;
      for (k = 0; (2 * k + 1) * i <= 62; k++) begin
         n = 2 * k + 1;
         t = udiv(64'd1 << (62 - n * i), 64'(n));
         if (k[0]) acc = acc - t;
         else acc = acc + t;
      end
      return acc;
   endfunction

   function automatic longint unsigned atan_third_q62();
      longint unsigned p;
      longint unsigned acc;
      longint unsigned t;
      int unsigned     k;
      p   = udiv(64'd1 << 62, 64'd3);
      acc = 64'd0;
      k   = 0;
      while (p != 64'd0) begin
         t = udiv(p, 64'(2 * k + 1));
         if (k[0]) acc = acc - t;
         else acc = acc + t;
         p = udiv(p, 64'd9);
         k++;
      end
      return acc;
   endfunction

   function automatic longint unsigned atan_one_q62();
      return atan_pow2_q62(1) + atan_third_q62();
   endfunction

   function automatic longint unsigned atan_frac(input int unsigned i, input int unsigned f);
      longint unsigned a;
      a = (i == 0) ? atan_one_q62() : atan_pow2_q62(i);
      return (a + (64'd1 << (61 - f))) >> (62 - f);
   endfunction

   function automatic longint unsigned pi_frac(input int unsigned f);
      return (atan_one_q62() + (64'd1 << (59 - f))) >> (60 - f);
   endfunction

   function automatic longint unsigned half_pi_frac(input int unsigned f);
      return (atan_one_q62() + (64'd1 << (60 - f))) >> (61 - f);
   endfunction

   function automatic longint unsigned cordic_gain(input int unsigned n);
      longint unsigned prod;
      longint unsigned v;
      longint unsigned res;
      longint unsigned bt;
      longint unsigned num;
      int unsigned     i;
      prod = 64'd1 << 61;
      for (i = 1; i < n; i++) prod = prod + (prod >> (2 * i));
      v   = prod;
      res = 64'd0;
      bt  = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 64'd0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      num = (64'd1 << 60) + (res >> 1);
      return udiv(num, res);
   endfunction

endpackage

FILE: hdl/euler_to_quaternion.sv
// The CORDIC stage count is clamped to 1..24.
// Throughput: one item per cycle unless a stalled result backs up to the input; each pipeline stage holds one item.
// A stalled result only holds the stages behind it that are full.
// Reset clears the stage valid flags; the data path registers are not reset.
// ----------------------------------------------------------------------------
// Euler to quaternion converter
// Three CORDIC lanes form half-angle cosines and sines; a merge pipeline
// forms the Z-Y-X unit quaternion in Q1.14.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int CORDIC_STAGES = 16,
   parameter int ANGLE_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  e2q_pkg::angle_type req_roll_angle,
   input  e2q_pkg::angle_type req_pitch_angle,
   input  e2q_pkg::angle_type req_yaw_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output e2q_pkg::quat_type  rsp_quat_w,
   output e2q_pkg::quat_type  rsp_quat_x,
   output e2q_pkg::quat_type  rsp_quat_y,
   output e2q_pkg::quat_type  rsp_quat_z
);

   localparam int N = (CORDIC_STAGES < 1) ? 1 :
                      (CORDIC_STAGES > e2q_pkg::TAB_MAX) ? e2q_pkg::TAB_MAX : CORDIC_STAGES;
   localparam int F = (ANGLE_BITS - 3 < 1) ? 1 : (ANGLE_BITS - 3 > 29) ? 29 : ANGLE_BITS - 3;
   localparam int LANE_D = N + 2;
   localparam int D = LANE_D + e2q_pkg::MERGE_STAGES;

   logic [D-1:0]      valid_ff;
   logic [D-1:0]      en;
   e2q_pkg::data_type cr, sr, cp, sp, cy, sy;

   always_comb begin
      en[D-1] = !valid_ff[D-1] || rsp_ready;
      for (int k = D - 2; k >= 0; k--) en[k] = !valid_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < D; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[D-1];

   e2q_cordic_lane #(.STAGES(N), .FRAC(F)) u_roll (
      .clock(clock), .stage_en(en[LANE_D-1:0]), .angle(req_roll_angle),
      .cos_out(cr), .sin_out(sr)
   );

   e2q_cordic_lane #(.STAGES(N), .FRAC(F)) u_pitch (
      .clock(clock), .stage_en(en[LANE_D-1:0]), .angle(req_pitch_angle),
      .cos_out(cp), .sin_out(sp)
   );

   e2q_cordic_lane #(.STAGES(N), .FRAC(F)) u_yaw (
      .clock(clock), .stage_en(en[LANE_D-1:0]), .angle(req_yaw_angle),
      .cos_out(cy), .sin_out(sy)
   );

   e2q_merge u_merge (
      .clock(clock), .stage_en(en[D-1:LANE_D]),
      .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y), .quat_z(rsp_quat_z)
   );

endmodule

FILE: hdl/e2q_cordic_lane.sv
// ----------------------------------------------------------------------------
// Half-angle CORDIC lane
// Halves one angle, folds it into +-pi/2 and rotates it through a pipeline.
// ----------------------------------------------------------------------------
module e2q_cordic_lane #(
   parameter int STAGES = 16,
   parameter int FRAC   = 13
) (
   input  logic                     clock,
   input  logic [STAGES+1:0]        stage_en,
   input  e2q_pkg::angle_type       angle,
   output e2q_pkg::data_type        cos_out,
   output e2q_pkg::data_type        sin_out
);

   localparam int ZW = FRAC + 4;
   localparam logic signed [ZW-1:0] PI_C  = ZW'(e2q_pkg::pi_frac(FRAC));
   localparam logic signed [ZW-1:0] HPI_C = ZW'(e2q_pkg::half_pi_frac(FRAC));
   localparam e2q_pkg::data_type GAIN_C =
      e2q_pkg::DATA_W'(e2q_pkg::cordic_gain(STAGES));

   e2q_pkg::data_type       x_ff [0:STAGES];
   e2q_pkg::data_type       y_ff [0:STAGES];
   logic signed [ZW-1:0]    z_ff [0:STAGES];
   logic                    neg_ff [0:STAGES];
   logic signed [ZW-1:0]    z_half;
   e2q_pkg::data_type       cos_ff;
   e2q_pkg::data_type       sin_ff;

   generate
      if (FRAC >= 14) begin : g_wide
         assign z_half = {{(ZW-e2q_pkg::ANG_W){angle[e2q_pkg::ANG_W-1]}}, angle}
                         <<< (FRAC - 14);
      end else begin : g_narrow
         logic signed [e2q_pkg::ANG_W+1:0] rnd;
         logic signed [e2q_pkg::ANG_W+1:0] shf;
         assign rnd = {{2{angle[e2q_pkg::ANG_W-1]}}, angle}
                      + (18'sd1 <<< (13 - FRAC));
         assign shf = rnd >>> (14 - FRAC);
         assign z_half = shf[ZW-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0] <= GAIN_C;
         y_ff[0] <= '0;
         if (z_half > HPI_C) begin
            z_ff[0]   <= z_half - PI_C;
            neg_ff[0] <= 1'b1;
         end else if (z_half < -HPI_C) begin
            z_ff[0]   <= z_half + PI_C;
            neg_ff[0] <= 1'b1;
         end else begin
            z_ff[0]   <= z_half;
            neg_ff[0] <= 1'b0;
         end
      end
   end

   generate
      for (genvar i = 0; i < STAGES; i++) begin : g_iter
         localparam logic signed [ZW-1:0] ATAN_C = ZW'(e2q_pkg::atan_frac(i, FRAC));
         always_ff @(posedge clock) begin
            if (stage_en[i+1]) begin
               neg_ff[i+1] <= neg_ff[i];
               if (!z_ff[i][ZW-1]) begin
                  x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
                  y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
                  z_ff[i+1] <= z_ff[i] - ATAN_C;
               end else begin
                  x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
                  y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
                  z_ff[i+1] <= z_ff[i] + ATAN_C;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en[STAGES+1]) begin
         cos_ff <= neg_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
         sin_ff <= neg_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: hdl/e2q_merge.sv
// ----------------------------------------------------------------------------
// Quaternion merge
// Combines the three lanes' cosines and sines into w, x, y and z.
// ----------------------------------------------------------------------------
module e2q_merge (
   input  logic                                clock,
   input  logic [e2q_pkg::MERGE_STAGES-1:0]    stage_en,
   input  e2q_pkg::data_type                   cr,
   input  e2q_pkg::data_type                   sr,
   input  e2q_pkg::data_type                   cp,
   input  e2q_pkg::data_type                   sp,
   input  e2q_pkg::data_type                   cy,
   input  e2q_pkg::data_type                   sy,
   output e2q_pkg::quat_type                   quat_w,
   output e2q_pkg::quat_type                   quat_x,
   output e2q_pkg::quat_type                   quat_y,
   output e2q_pkg::quat_type                   quat_z
);

   localparam int PW = 2 * e2q_pkg::DATA_W;
   localparam int TW = e2q_pkg::PAIR_W + e2q_pkg::DATA_W;
   localparam int SW = e2q_pkg::SUM_W;
   localparam int OSH = 2 * e2q_pkg::DATA_FR - 14;

   typedef logic signed [PW-1:0]                 prod_type;
   typedef logic signed [e2q_pkg::PAIR_W-1:0]    pair_type;
   typedef logic signed [TW-1:0]                 term_type;
   typedef logic signed [SW-1:0]                 sum_type;

   prod_type            crcp_p_ff, srsp_p_ff, srcp_p_ff, crsp_p_ff;
   e2q_pkg::data_type   cy1_ff, sy1_ff, cy2_ff, sy2_ff;
   pair_type            crcp_ff, srsp_ff, srcp_ff, crsp_ff;
   term_type            t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff;
   e2q_pkg::quat_type   w_ff, x_ff, y_ff, z_ff;

   function automatic pair_type round_pair(input prod_type p);
      prod_type r;
      r = (p + (prod_type'(1) <<< (e2q_pkg::DATA_FR - 1))) >>> e2q_pkg::DATA_FR;
      return r[e2q_pkg::PAIR_W-1:0];
   endfunction

   function automatic e2q_pkg::quat_type to_q14(input term_type a, input term_type b,
                                                input logic sub);
      sum_type s;
      sum_type r;
      s = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
      r = (s + (sum_type'(1) <<< (OSH - 1))) >>> OSH;
      if (r > sum_type'(e2q_pkg::Q_ONE)) r = sum_type'(e2q_pkg::Q_ONE);
      if (r < -sum_type'(e2q_pkg::Q_ONE)) r = -sum_type'(e2q_pkg::Q_ONE);
      return r[e2q_pkg::QUAT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         crcp_p_ff <= cr * cp;
         srsp_p_ff <= sr * sp;
         srcp_p_ff <= sr * cp;
         crsp_p_ff <= cr * sp;
         cy1_ff    <= cy;
         sy1_ff    <= sy;
      end
      if (stage_en[1]) begin
         crcp_ff <= round_pair(crcp_p_ff);
         srsp_ff <= round_pair(srsp_p_ff);
         srcp_ff <= round_pair(srcp_p_ff);
         crsp_ff <= round_pair(crsp_p_ff);
         cy2_ff  <= cy1_ff;
         sy2_ff  <= sy1_ff;
      end
      if (stage_en[2]) begin
         t0_ff <= crcp_ff * cy2_ff;
         t1_ff <= srsp_ff * sy2_ff;
         t2_ff <= srcp_ff * cy2_ff;
         t3_ff <= crsp_ff * sy2_ff;
         t4_ff <= crsp_ff * cy2_ff;
         t5_ff <= srcp_ff * sy2_ff;
         t6_ff <= crcp_ff * sy2_ff;
         t7_ff <= srsp_ff * cy2_ff;
      end
      if (stage_en[3]) begin
         w_ff <= to_q14(t0_ff, t1_ff, 1'b0);
         x_ff <= to_q14(t2_ff, t3_ff, 1'b1);
         y_ff <= to_q14(t4_ff, t5_ff, 1'b0);
         z_ff <= to_q14(t6_ff, t7_ff, 1'b1);
      end
   end

   assign quat_w = w_ff;
   assign quat_x = x_ff;
   assign quat_y = y_ff;
   assign quat_z = z_ff;

endmodule
